// ===== rtl/core/base64url_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// base64url_decoder assertion macros
// Shorthand for clocked concurrent assertions that are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BASE64URL_DECODER_ASSERT_SVH
`define BASE64URL_DECODER_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds at the same edge.
`define B64D_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("base64url_decoder: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons holds at the next edge.
`define B64D_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("base64url_decoder: next-cycle check failed");

`endif

// ===== rtl/core/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, character constants and the alphabet lookup of the Base64url decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int CHAR_W   = 8;
    localparam int SEXTET_W = 6;

    localparam logic [CHAR_W-1:0] CHAR_PAD   = 8'h3D; // '='
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B; // '+'
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F; // '/'
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D; // '-'
    localparam logic [CHAR_W-1:0] CHAR_UNDER = 8'h5F; // '_'
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_D0    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_D9    = 8'h39;

    localparam logic [SEXTET_W-1:0] VAL_LC_BASE = 6'd26;
    localparam logic [SEXTET_W-1:0] VAL_D_BASE  = 6'd52;
    localparam logic [SEXTET_W-1:0] VAL_62      = 6'd62;
    localparam logic [SEXTET_W-1:0] VAL_63      = 6'd63;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] byte_value;
        logic              byte_valid;
        logic              done_res;
        logic              bad_input;
    } out_item_t;

    typedef struct packed {
        logic                ok;
        logic [SEXTET_W-1:0] value;
    } sextet_t;

    // Maps a character of either alphabet to its 6-bit value; ok is low
    // for any other code.
    function automatic sextet_t sextet_of(input logic [CHAR_W-1:0] c);
        sextet_t r;
        logic [CHAR_W-1:0] off;
        r   = '{ok: 1'b0, value: '0};
        off = '0;
        if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            off = c - CHAR_UC_A;
            r   = '{ok: 1'b1, value: off[SEXTET_W-1:0]};
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            off = c - CHAR_LC_A;
            r   = '{ok: 1'b1, value: off[SEXTET_W-1:0] + VAL_LC_BASE};
        end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
            off = c - CHAR_D0;
            r   = '{ok: 1'b1, value: off[SEXTET_W-1:0] + VAL_D_BASE};
        end else if (c == CHAR_MINUS || c == CHAR_PLUS) begin
            r   = '{ok: 1'b1, value: VAL_62};
        end else if (c == CHAR_UNDER || c == CHAR_SLASH) begin
            r   = '{ok: 1'b1, value: VAL_63};
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/b64d_stream_if.sv =====
// ----------------------------------------------------------------------------
// b64d_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface b64d_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/base64url_decoder.sv =====
// ----------------------------------------------------------------------------
// base64url_decoder
// Streaming Base64url decoder, one character in and at most one byte out.
// ----------------------------------------------------------------------------
// Usage: characters arrive on the chars channel, one per transfer, with
// last_char marking the final character of a string. Results leave on the
// bytes channel. A character yields a result when it completes a byte, when
// it is the last one of its string, or both at once in a single result.
// A result is presented in the cycle after the transfer of the character
// that causes it. Throughput is one character per cycle while the receiver
// takes each result, set by the single result register, which is reloaded
// in the same cycle that its previous content is taken.
// Padding or a character outside both alphabets stops decoding; later
// characters are swallowed until the last one, whose result reports the
// error flag (set by a bad character, not by padding). The state then returns
// to empty for the next string. When the receiver stalls, the result
// register holds its content and the chars channel stays ready only while
// the register is empty: while a result waits there, no character is taken,
// not even one that yields no result. Reset clears the decoding state and
// empties the result register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module base64url_decoder (
    input  logic          clk,
    input  logic          rst_n,
    b64d_stream_if.sink   chars,
    b64d_stream_if.source bytes
);
    import b64d_pkg::*;

    // Decoding state. Only the previous sextet is kept: with at most six
    // pending bits, a byte never reaches further back than that.
    logic [SEXTET_W-1:0] sextet_reg, sextet_next;
    logic [2:0]          pending_reg, pending_next;
    logic                halted_reg, halted_next;
    logic                error_reg, error_next;

    // Result register.
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_item_reg, out_item_next;

    logic                in_fire;
    logic                emit;
    in_item_t            item;
    sextet_t             sx;
    logic [3:0]          bits_sum;
    logic [2:0]          shift;
    logic [2*SEXTET_W-1:0] window;
    logic [2*SEXTET_W-1:0] shifted;

    assign item        = chars.payload;
    assign chars.ready = !out_valid_reg || bytes.ready;
    assign in_fire     = chars.valid && chars.ready;

    assign sx       = sextet_of(item.char_code);
    assign bits_sum = {1'b0, pending_reg} + 4'd6;
    assign window   = {sextet_reg, sx.value};
    // A byte is taken from the top of the pending bits; what is left over
    // (0, 2 or 4 bits) sits below it.
    assign shift    = bits_sum[2:0];
    assign shifted  = window >> shift;

    always_comb
    begin
        sextet_next    = sextet_reg;
        pending_next   = pending_reg;
        halted_next    = halted_reg;
        error_next     = error_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !bytes.ready;
        emit           = 1'b0;

        if (in_fire)
        begin
            out_item_next = '{byte_value: '0, byte_valid: 1'b0,
                              done_res: item.last_char, bad_input: 1'b0};

            if (!halted_reg)
            begin
                if (item.char_code == CHAR_PAD)
                begin
                    halted_next = 1'b1;
                end
                else if (!sx.ok)
                begin
                    error_next  = 1'b1;
                    halted_next = 1'b1;
                end
                else
                begin
                    sextet_next = sx.value;
                    if (bits_sum[3])
                    begin
                        out_item_next.byte_value = shifted[CHAR_W-1:0];
                        out_item_next.byte_valid = 1'b1;
                        pending_next             = bits_sum[2:0];
                    end
                    else
                    begin
                        pending_next = bits_sum[2:0];
                    end
                end
            end

            out_item_next.bad_input = item.last_char && error_next;
            emit = out_item_next.byte_valid || item.last_char;

            // The end of a string returns the decoder to its empty state.
            if (item.last_char)
            begin
                sextet_next  = '0;
                pending_next = '0;
                halted_next  = 1'b0;
                error_next   = 1'b0;
            end

            if (emit)
            begin
                out_valid_next = 1'b1;
            end
            else
            begin
                out_item_next = out_item_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sextet_reg    <= '0;
            pending_reg   <= '0;
            halted_reg    <= 1'b0;
            error_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sextet_reg    <= sextet_next;
            pending_reg   <= pending_next;
            halted_reg    <= halted_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign bytes.valid   = out_valid_reg;
    assign bytes.payload = out_item_reg;

endmodule

// ===== rtl/core/b64d_checker.sv =====
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the Base64url decoder, bound to its top level.
// ----------------------------------------------------------------------------
`include "base64url_decoder_assert.svh"

module b64d_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                in_last,
    input logic                out_valid,
    input logic                out_ready,
    input b64d_pkg::out_item_t out_item
);
    import b64d_pkg::*;

    // The error flag is only reported together with the end of a string.
    `B64D_ASSERT_IMP(a_bad_only_with_done, clk, rst_n,
        out_valid && out_item.bad_input, out_item.done_res)

    // A result carries a byte or ends a string; a result without a byte
    // shows a zero byte value.
    `B64D_ASSERT_IMP(a_result_has_purpose, clk, rst_n,
        out_valid && !out_item.byte_valid,
        out_item.done_res && (out_item.byte_value == '0))

    // The last character always yields its done result in the next cycle.
    `B64D_ASSERT_NXT(a_last_gives_done, clk, rst_n,
        in_valid && in_ready && in_last, out_valid && out_item.done_res)

    // A stalled result stays in place.
    `B64D_ASSERT_NXT(a_stall_holds, clk, rst_n,
        out_valid && !out_ready, out_valid && $stable(out_item))

endmodule

bind base64url_decoder b64d_checker u_b64d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .in_last   (chars.payload.last_char),
    .out_valid (bytes.valid),
    .out_ready (bytes.ready),
    .out_item  (bytes.payload)
);
